[design/iat_pkg.sv]
// shared types and constants of the integral image adaptive threshold block
// no dependencies; the controller, datapath, top level and checker import this package

package iat_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_VAL_W = 10;

  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 512;

  localparam int unsigned RST_FRAME_WIDTH  = 512;
  localparam int unsigned RST_FRAME_HEIGHT = 512;
  localparam int unsigned RST_SENSITIVITY  = 15;

  // full scale of the sensitivity percentage
  localparam int unsigned PCT_FULL = 100;
  // window half size is max(w,h) / 8 / 2
  localparam int unsigned WIN_SHIFT = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SENSITIVITY  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_COUNT,
    MUL_BASE_TOP,
    MUL_BASE_BOT,
    MUL_PIX_COUNT,
    MUL_LHS,
    MUL_RHS
  } mul_sel_e;

  // window corners in the order they are fetched
  typedef enum logic [1:0] {
    CORNER_BR,
    CORNER_TL,
    CORNER_TR,
    CORNER_BL
  } corner_e;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_value;
    logic             last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic     ld_start;
    logic     ld_rd;
    logic     ld_wr;
    logic     em_setup;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     rd_en;
    corner_e  rd_corner;
    logic     acc_clr;
    logic     acc_en;
    logic     out_load;
  } iat_cmd_t;

  typedef struct packed {
    logic frame_ready;
  } iat_status_t;

endpackage

[design/iat_chan_if.sv]
// valid/ready channel carrying one payload item per request
// payload type is given by the instantiating scope, usually from iat_pkg

interface iat_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/iat_ctrl.sv]
// controller of the threshold block: sequences loads and result requests
// depends on iat_pkg for the command and status structs

module iat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_action_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  iat_pkg::iat_status_t status_i,
  output iat_pkg::iat_cmd_t    cmd_o
);
  import iat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_EM_SET,
    S_EM_CNT,
    S_EM_BT,
    S_EM_BB,
    S_EM_R0,
    S_EM_R1,
    S_EM_R2,
    S_EM_R3,
    S_EM_R4,
    S_EM_RHS,
    S_EM_CMP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   take;
  logic   out_free;

  assign take     = in_ready_q && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_EM_CMP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            if (!in_action_i) begin
              state_q    <= S_LD_RD;
              in_ready_q <= 1'b0;
            end else if (status_i.frame_ready) begin
              state_q    <= S_EM_SET;
              in_ready_q <= 1'b0;
            end
          end
        end
        S_LD_RD:  state_q <= S_LD_WR;
        S_LD_WR: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
        S_EM_SET: state_q <= S_EM_CNT;
        S_EM_CNT: state_q <= S_EM_BT;
        S_EM_BT:  state_q <= S_EM_BB;
        S_EM_BB:  state_q <= S_EM_R0;
        S_EM_R0:  state_q <= S_EM_R1;
        S_EM_R1:  state_q <= S_EM_R2;
        S_EM_R2:  state_q <= S_EM_R3;
        S_EM_R3:  state_q <= S_EM_R4;
        S_EM_R4:  state_q <= S_EM_RHS;
        S_EM_RHS: state_q <= S_EM_CMP;
        S_EM_CMP: begin
          if (out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  // command decode per state
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.ld_start = take && !in_action_i;
      S_LD_RD:  cmd_o.ld_rd = 1'b1;
      S_LD_WR:  cmd_o.ld_wr = 1'b1;
      S_EM_SET: cmd_o.em_setup = 1'b1;
      S_EM_CNT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_COUNT;
      end
      S_EM_BT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BASE_TOP;
      end
      S_EM_BB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BASE_BOT;
      end
      S_EM_R0: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_corner = CORNER_BR;
        cmd_o.acc_clr   = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_PIX_COUNT;
      end
      S_EM_R1: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_corner = CORNER_TL;
        cmd_o.acc_en    = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_LHS;
      end
      S_EM_R2: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_corner = CORNER_TR;
        cmd_o.acc_en    = 1'b1;
      end
      S_EM_R3: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_corner = CORNER_BL;
        cmd_o.acc_en    = 1'b1;
      end
      S_EM_R4:  cmd_o.acc_en = 1'b1;
      S_EM_RHS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RHS;
      end
      S_EM_CMP: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

[design/iat_dp.sv]
// datapath of the threshold block: config registers, frame and integral
// memories, position counters, shared multiplier and compare; uses iat_pkg

module iat_dp #(
  parameter int unsigned MAX_WIDTH  = iat_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = iat_pkg::DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iat_pkg::iat_cmd_t    cmd_i,
  output iat_pkg::iat_status_t status_o,
  input  logic [iat_pkg::PIX_W-1:0] in_pixel_i,
  input  logic                 cfg_we_i,
  input  iat_pkg::cfg_item_t   cfg_item_i,
  output iat_pkg::out_item_t   out_item_o
);
  import iat_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CXW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = (XW > YW) ? XW : YW;
  localparam int unsigned EW    = CW + 1;
  localparam int unsigned IW    = AW + PIX_W;
  localparam int unsigned RSW   = CXW + PIX_W;
  localparam int unsigned MA    = IW + 1;
  localparam int unsigned MB    = (CW > PIX_W) ? CW : PIX_W;
  localparam int unsigned MP    = MA + MB;
  localparam int unsigned LW    = IW + PCT_W;

  // config and effective sizes
  logic [SIZE_W-1:0] fw_q, fh_q;
  logic [PCT_W-1:0]  pct_q, pct_eff;
  logic [XW-1:0]     w_eff;
  logic [YW-1:0]     h_eff;
  logic [CW-1:0]     big, s2;
  logic              cfg_known;
  logic              restart;

  // positions
  logic [CXW-1:0] ld_col_q, em_col_q;
  logic [RW-1:0]  ld_row_q, em_row_q;
  logic [AW-1:0]  ld_pos_q, em_pos_q;
  logic [RSW-1:0] rsum_q, rsum_d;
  logic           frame_ready_q;
  logic           ld_col_last, ld_row_last, em_col_last, em_row_last;

  // window
  logic [EW-1:0]  row_x, col_x, s2_x, hi_row, hi_col;
  logic [RW-1:0]  y1_d, y2_d, y1_q, y2_q;
  logic [CXW-1:0] x1_d, x2_d, x1_q, x2_q;
  logic           last_q;

  // memories
  logic [IW-1:0]    int_mem [Depth];
  logic [PIX_W-1:0] pix_mem [Depth];
  logic [AW-1:0]    int_addr, corner_addr;
  logic [IW-1:0]    int_wdata, int_rdata_q, above;
  logic             int_re;
  logic [PIX_W-1:0] pix_q, pix_rd_q;

  // corner fetch and accumulate
  logic           use_bot, use_right, corner_zero;
  logic [RW-1:0]  cy;
  logic [CXW-1:0] cx;
  logic [AW-1:0]  cbase;
  corner_e        rd_corner_q;
  logic           rd_zero_q;
  logic [MA-1:0]  sum_q, acc_val;

  // shared multiplier
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [MP-1:0] prod;
  logic [AW-1:0] count_q, base_top_q, base_bot_q;
  logic [IW-1:0] pc_q;
  logic [LW-1:0] lhs_q, rhs_q;

  out_item_t res_q;

  // sizes saturate into the supported range
  always_comb begin
    if (fw_q == '0) begin
      w_eff = XW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = YW'(1);
    end else if (32'(fh_q) > MAX_HEIGHT) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(fh_q);
    end
  end

  assign pct_eff = (pct_q > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_q;
  assign big     = (CW'(w_eff) > CW'(h_eff)) ? CW'(w_eff) : CW'(h_eff);
  assign s2      = big >> WIN_SHIFT;

  always_comb begin
    unique case (cfg_reg_e'(cfg_item_i.index))
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_SENSITIVITY: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  assign restart = (cmd_i.ld_start && frame_ready_q) || (cfg_we_i && cfg_known);

  assign ld_col_last = XW'(ld_col_q) == (w_eff - XW'(1));
  assign ld_row_last = YW'(ld_row_q) == (h_eff - YW'(1));
  assign em_col_last = XW'(em_col_q) == (w_eff - XW'(1));
  assign em_row_last = YW'(em_row_q) == (h_eff - YW'(1));

  assign rsum_d = ((ld_col_q == '0) ? '0 : rsum_q) + RSW'(pix_q);

  // clamped window corners of the pixel at the emit position
  assign row_x  = EW'(em_row_q);
  assign col_x  = EW'(em_col_q);
  assign s2_x   = EW'(s2);
  assign hi_row = row_x + s2_x;
  assign hi_col = col_x + s2_x;
  assign y1_d   = (row_x >= s2_x) ? RW'(row_x - s2_x) : '0;
  assign y2_d   = (hi_row >= EW'(h_eff)) ? RW'(EW'(h_eff) - EW'(1)) : RW'(hi_row);
  assign x1_d   = (col_x >= s2_x) ? CXW'(col_x - s2_x) : '0;
  assign x2_d   = (hi_col >= EW'(w_eff)) ? CXW'(EW'(w_eff) - EW'(1)) : CXW'(hi_col);

  // corner address; a corner on row 0 or column 0 reads as zero
  assign use_bot     = (cmd_i.rd_corner == CORNER_BR) || (cmd_i.rd_corner == CORNER_BL);
  assign use_right   = (cmd_i.rd_corner == CORNER_BR) || (cmd_i.rd_corner == CORNER_TR);
  assign cy          = use_bot ? y2_q : y1_q;
  assign cx          = use_right ? x2_q : x1_q;
  assign cbase       = use_bot ? base_bot_q : base_top_q;
  assign corner_zero = (cy == '0) || (cx == '0);
  assign corner_addr = cbase + AW'(cx) - AW'(1);

  always_comb begin
    priority if (cmd_i.ld_wr) begin
      int_addr = ld_pos_q;
    end else if (cmd_i.ld_rd) begin
      int_addr = ld_pos_q - AW'(w_eff);
    end else begin
      int_addr = corner_addr;
    end
  end

  assign int_re    = cmd_i.ld_rd || cmd_i.rd_en;
  assign above     = (ld_row_q != '0) ? int_rdata_q : '0;
  assign int_wdata = above + IW'(rsum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr) begin
      int_mem[int_addr] <= int_wdata;
    end
    if (int_re) begin
      int_rdata_q <= int_mem[int_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr) begin
      pix_mem[ld_pos_q] <= pix_q;
    end
    if (cmd_i.em_setup) begin
      pix_rd_q <= pix_mem[em_pos_q];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_COUNT: begin
        mul_a = MA'(x2_q - x1_q);
        mul_b = MB'(y2_q - y1_q);
      end
      MUL_BASE_TOP: begin
        mul_a = MA'(y1_q - RW'(1));
        mul_b = MB'(w_eff);
      end
      MUL_BASE_BOT: begin
        mul_a = MA'(y2_q - RW'(1));
        mul_b = MB'(w_eff);
      end
      MUL_PIX_COUNT: begin
        mul_a = MA'(count_q);
        mul_b = MB'(pix_rd_q);
      end
      MUL_LHS: begin
        mul_a = MA'(pc_q) + MA'(1);
        mul_b = MB'(PCT_FULL);
      end
      MUL_RHS: begin
        mul_a = sum_q;
        mul_b = MB'(PCT_W'(PCT_FULL) - pct_eff);
      end
      default: ;
    endcase
  end

  assign prod = MP'(mul_a) * MP'(mul_b);

  assign acc_val = rd_zero_q ? '0 : MA'(int_rdata_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_start) begin
      pix_q <= in_pixel_i;
    end
    if (cmd_i.em_setup) begin
      y1_q   <= y1_d;
      y2_q   <= y2_d;
      x1_q   <= x1_d;
      x2_q   <= x2_d;
      last_q <= em_col_last && em_row_last;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MUL_COUNT:     count_q    <= AW'(prod);
        MUL_BASE_TOP:  base_top_q <= AW'(prod);
        MUL_BASE_BOT:  base_bot_q <= AW'(prod);
        MUL_PIX_COUNT: pc_q       <= IW'(prod);
        MUL_LHS:       lhs_q      <= LW'(prod);
        MUL_RHS:       rhs_q      <= LW'(prod);
        default: ;
      endcase
    end
    if (cmd_i.rd_en) begin
      rd_corner_q <= cmd_i.rd_corner;
      rd_zero_q   <= corner_zero;
    end
    // both adds come first so the running value never goes below zero
    if (cmd_i.acc_clr) begin
      sum_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (rd_corner_q == CORNER_BR || rd_corner_q == CORNER_TL) begin
        sum_q <= sum_q + acc_val;
      end else begin
        sum_q <= sum_q - acc_val;
      end
    end
    if (cmd_i.out_load) begin
      res_q.out_value  <= (lhs_q <= rhs_q) ? PIX_MAX : '0;
      res_q.last_pixel <= last_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q          <= SIZE_W'(RST_FRAME_WIDTH);
      fh_q          <= SIZE_W'(RST_FRAME_HEIGHT);
      pct_q         <= PCT_W'(RST_SENSITIVITY);
      ld_col_q      <= '0;
      ld_row_q      <= '0;
      ld_pos_q      <= '0;
      em_col_q      <= '0;
      em_row_q      <= '0;
      em_pos_q      <= '0;
      rsum_q        <= '0;
      frame_ready_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_item_i.index))
          REG_FRAME_WIDTH:  fw_q  <= cfg_item_i.value;
          REG_FRAME_HEIGHT: fh_q  <= cfg_item_i.value;
          REG_SENSITIVITY:  pct_q <= cfg_item_i.value[PCT_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        ld_col_q      <= '0;
        ld_row_q      <= '0;
        ld_pos_q      <= '0;
        em_col_q      <= '0;
        em_row_q      <= '0;
        em_pos_q      <= '0;
        rsum_q        <= '0;
        frame_ready_q <= 1'b0;
      end else begin
        if (cmd_i.ld_rd) begin
          rsum_q <= rsum_d;
        end
        if (cmd_i.ld_wr) begin
          if (ld_col_last && ld_row_last) begin
            ld_col_q      <= '0;
            ld_row_q      <= '0;
            ld_pos_q      <= '0;
            em_col_q      <= '0;
            em_row_q      <= '0;
            em_pos_q      <= '0;
            frame_ready_q <= 1'b1;
          end else if (ld_col_last) begin
            ld_col_q <= '0;
            ld_row_q <= ld_row_q + RW'(1);
            ld_pos_q <= ld_pos_q + AW'(1);
          end else begin
            ld_col_q <= ld_col_q + CXW'(1);
            ld_pos_q <= ld_pos_q + AW'(1);
          end
        end
        if (cmd_i.em_setup) begin
          if (em_col_last && em_row_last) begin
            em_col_q <= '0;
            em_row_q <= '0;
            em_pos_q <= '0;
          end else if (em_col_last) begin
            em_col_q <= '0;
            em_row_q <= em_row_q + RW'(1);
            em_pos_q <= em_pos_q + AW'(1);
          end else begin
            em_col_q <= em_col_q + CXW'(1);
            em_pos_q <= em_pos_q + AW'(1);
          end
        end
      end
    end
  end

  assign status_o.frame_ready = frame_ready_q;
  assign out_item_o           = res_q;

endmodule

[design/integral_image_adaptive_threshold.sv]
// top level of the integral image adaptive threshold block
// depends on iat_pkg, iat_chan_if, iat_ctrl and iat_dp

// Load requests (action 0) write one 8-bit pixel each, in raster order, into a
// frame memory, while an integral image of the frame is built alongside it from
// a running row sum and the entry one row above. Once width*height pixels are in,
// every result request (action 1) returns one binary pixel in raster order: 255
// when the pixel times the window pixel count, plus one, times 100 is no more
// than the window sum times (100 - sensitivity), otherwise 0. The window is
// centered on the pixel with half size max(w,h)/16 and clamped to the frame;
// last_pixel marks the final pixel, after which output restarts at pixel 0.
// A request before the frame is complete is taken and gives no result. A load
// after a complete frame starts a new frame, as does any write to a defined
// register. A load runs through accept, a read of the entry above and a write
// of both memories, as the integral memory has a single port. A result
// request runs from accept through window setup, three passes of the one
// shared multiplier for count and row bases, four corner reads through the
// single integral memory port overlapped with two more multiplies, the final
// multiply and the compare, which waits while the output register is full.
// The result sits there, so the next request is taken while it waits to be taken.
// Both memories come up undefined and get no clearing pass; the block is ready
// right after reset. Config writes are always accepted and must only come while
// the block is idle.

module integral_image_adaptive_threshold #(
  parameter int unsigned MAX_WIDTH  = iat_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = iat_pkg::DEF_MAX_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iat_chan_if.sink   in_i,
  iat_chan_if.source out_o,
  iat_chan_if.sink   cfg_i
);
  import iat_pkg::*;

  iat_cmd_t    cmd;
  iat_status_t status;
  in_item_t    in_item;
  cfg_item_t   cfg_item;
  out_item_t   out_item;
  logic        in_ready;
  logic        out_valid;
  logic        cfg_we;

  assign in_item  = in_i.data;
  assign cfg_item = cfg_i.data;

  // register writes never stall
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_item;

  // sequencer: one load or one request in flight at a time
  iat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_item.action),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // memories, counters, shared multiplier and result register
  iat_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_pixel_i (in_item.pixel),
    .cfg_we_i   (cfg_we),
    .cfg_item_i (cfg_item),
    .out_item_o (out_item)
  );

endmodule

[design/iat_checker.sv]
// port-level checks of the threshold block, bound to the top level
// depends on iat_pkg and integral_image_adaptive_threshold

module iat_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_action_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [iat_pkg::PIX_W-1:0] out_value_i,
  input logic                      out_last_i
);
  import iat_pkg::*;

  // results are strictly binary
  a_out_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_value_i == '0 || out_value_i == PIX_MAX))
    else $error("result value is neither 0 nor 255");

  // a load never produces a result right behind it
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_action_i) |=> !$rose(out_valid_i))
    else $error("result appeared right after a load");

  // a load keeps the block busy, so input is not ready right after it
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_action_i) |=> !in_ready_i)
    else $error("input ready right after a load");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_value_i) && $stable(out_last_i)))
    else $error("stalled result dropped or changed");

endmodule

bind integral_image_adaptive_threshold iat_checker u_iat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.data.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.data.out_value),
  .out_last_i  (out_o.data.last_pixel)
);
